/* rtl/ptn_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptn_pkg
// Shared constants, codes and controller/datapath interface types for the
// gradient noise and turbulence block.
// ----------------------------------------------------------------------------
package ptn_pkg;

   localparam int FRAC_BITS = 16;
   localparam int GRAD_FRAC = 14;
   localparam int TAB_W     = 8;
   localparam int TAB_DEPTH = 1 << TAB_W;
   localparam int GRAD_W    = 16;
   localparam int PT_W      = 32;
   localparam int OUT_W     = 20;
   localparam int OCT_W     = 4;
   localparam int MAX_OCT   = 8;
   localparam int NOISE_W   = 26;
   localparam int ACC_W     = 28;
   localparam int FUNC_W    = 3;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 4;

   localparam int OUT_MAX = 262144;

   // function codes of the request channel
   localparam logic [FUNC_W-1:0] FUNC_EVAL   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_GRAD   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PERM_X = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PERM_Y = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_PERM_Z = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_OCTAVES = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE    = 4'd1;

   localparam logic [OCT_W-1:0] OCT_RESET  = 4'd7;
   localparam logic [OCT_W-1:0] OCT_LIMIT  = 4'(MAX_OCT);

   typedef struct packed {
      logic       load;
      logic       smooth_a;
      logic       smooth_b;
      logic       issue;
      logic [2:0] corner;
      logic       oct_end;
      logic [2:0] octave;
      logic       finish;
   } ptn_cmd_type;

   typedef struct packed {
      logic             busy;
      logic             out_free;
      logic [OCT_W-1:0] oct_limit;
   } ptn_status_type;

endpackage

/* rtl/ptn_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptn_datapath
// Tables, configuration registers, smoothstep unit, corner pipeline,
// octave accumulator and result register.
// ----------------------------------------------------------------------------
module ptn_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  ptn_pkg::ptn_cmd_type                 cmd,
   output ptn_pkg::ptn_status_type              status,
   input  logic [ptn_pkg::FUNC_W-1:0]           req_func,
   input  logic [ptn_pkg::TAB_W-1:0]            req_table_index,
   input  logic signed [ptn_pkg::GRAD_W-1:0]    req_grad_x,
   input  logic signed [ptn_pkg::GRAD_W-1:0]    req_grad_y,
   input  logic signed [ptn_pkg::GRAD_W-1:0]    req_grad_z,
   input  logic [ptn_pkg::TAB_W-1:0]            req_perm_value,
   input  logic signed [ptn_pkg::PT_W-1:0]      req_point_x,
   input  logic signed [ptn_pkg::PT_W-1:0]      req_point_y,
   input  logic signed [ptn_pkg::PT_W-1:0]      req_point_z,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptn_pkg::CSR_DAT_W-1:0]        csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ptn_pkg::OUT_W-1:0]     rsp_noise_value
);
   import ptn_pkg::*;

   localparam int GW3 = 3 * GRAD_W;
   localparam logic [FRAC_BITS:0]   ONE_W     = (FRAC_BITS+1)'(1 << FRAC_BITS);
   localparam logic [FRAC_BITS+1:0] THREE_ONE = (FRAC_BITS+2)'(3 << FRAC_BITS);
   localparam logic signed [FRAC_BITS+1:0] ONE_S = (FRAC_BITS+2)'(1 << FRAC_BITS);

   // configuration
   logic [OCT_W-1:0] octaves_ff;
   logic             mode_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         octaves_ff <= OCT_RESET;
         mode_ff    <= 1'b1;
      end else if (csr_valid) begin
         if (csr_index == CSR_OCTAVES) octaves_ff <= csr_wdata[OCT_W-1:0];
         else if (csr_index == CSR_MODE) mode_ff <= csr_wdata[0];
      end
   end

   // sample point, doubled after each octave
   logic [PT_W-1:0] pt_ff [3];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pt_ff[0] <= req_point_x;
         pt_ff[1] <= req_point_y;
         pt_ff[2] <= req_point_z;
      end else if (cmd.oct_end) begin
         for (int a = 0; a < 3; a++) pt_ff[a] <= {pt_ff[a][PT_W-2:0], 1'b0};
      end
   end

   logic [FRAC_BITS-1:0] frac [3];
   logic [TAB_W-1:0]     lat  [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         frac[a] = pt_ff[a][FRAC_BITS-1:0];
         lat[a]  = pt_ff[a][FRAC_BITS+TAB_W-1:FRAC_BITS];
      end
   end

   // smoothstep: f*f, then times (3 - 2f)
   logic [FRAC_BITS-1:0] f2_ff [3];
   logic [FRAC_BITS+1:0] tt_ff [3];
   logic [FRAC_BITS:0]   sm_ff [3];
   logic [2*FRAC_BITS-1:0] sq   [3];
   logic [2*FRAC_BITS+1:0] smp  [3];

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         sq[a]  = frac[a] * frac[a];
         smp[a] = f2_ff[a] * tt_ff[a];
      end
   end

   always_ff @(posedge clock) begin
      for (int a = 0; a < 3; a++) begin
         if (cmd.smooth_a) begin
            f2_ff[a] <= sq[a][2*FRAC_BITS-1:FRAC_BITS];
            tt_ff[a] <= THREE_ONE - {1'b0, frac[a], 1'b0};
         end
         if (cmd.smooth_b) sm_ff[a] <= smp[a][2*FRAC_BITS:FRAC_BITS];
      end
   end

   // tables
   logic [GW3-1:0]   grad_mem  [TAB_DEPTH];
   logic [TAB_W-1:0] permx_mem [TAB_DEPTH];
   logic [TAB_W-1:0] permy_mem [TAB_DEPTH];
   logic [TAB_W-1:0] permz_mem [TAB_DEPTH];

   logic [TAB_W-1:0] permx_rd_ff, permy_rd_ff, permz_rd_ff;
   logic [GW3-1:0]   grad_rd_ff;
   logic [TAB_W-1:0] ax, ay, az, hash;

   assign ax   = lat[0] + TAB_W'(cmd.corner[2]);
   assign ay   = lat[1] + TAB_W'(cmd.corner[1]);
   assign az   = lat[2] + TAB_W'(cmd.corner[0]);
   assign hash = permx_rd_ff ^ permy_rd_ff ^ permz_rd_ff;

   always_ff @(posedge clock) begin
      if (cmd.load && req_func == FUNC_PERM_X) permx_mem[req_table_index] <= req_perm_value;
      if (cmd.load && req_func == FUNC_PERM_Y) permy_mem[req_table_index] <= req_perm_value;
      if (cmd.load && req_func == FUNC_PERM_Z) permz_mem[req_table_index] <= req_perm_value;
      permx_rd_ff <= permx_mem[ax];
      permy_rd_ff <= permy_mem[ay];
      permz_rd_ff <= permz_mem[az];
   end

   always_ff @(posedge clock) begin
      if (cmd.load && req_func == FUNC_GRAD)
         grad_mem[req_table_index] <= {req_grad_x, req_grad_y, req_grad_z};
      grad_rd_ff <= grad_mem[hash];
   end

   // corner pipeline control
   logic       s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [2:0] s1_c_ff, s2_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= cmd.issue;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= s2_v_ff;
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_c_ff <= cmd.corner;
      s2_c_ff <= s1_c_ff;
   end

   // stage 2: offset products and x*y weight
   logic signed [GRAD_W-1:0]    gx, gy, gz;
   logic signed [FRAC_BITS+1:0] ox, oy, oz;
   logic [FRAC_BITS:0]          wx, wy, wz;
   logic [2*FRAC_BITS+1:0]      wxy;
   logic signed [GRAD_W+FRAC_BITS+1:0] prx, pry, prz;
   logic signed [GRAD_W+FRAC_BITS+1:0] prx_ff, pry_ff, prz_ff;
   logic [FRAC_BITS:0]          wxy_ff, wz_ff;

   always_comb begin
      gx  = grad_rd_ff[GW3-1:2*GRAD_W];
      gy  = grad_rd_ff[2*GRAD_W-1:GRAD_W];
      gz  = grad_rd_ff[GRAD_W-1:0];
      ox  = $signed({2'b00, frac[0]}) - (s2_c_ff[2] ? ONE_S : '0);
      oy  = $signed({2'b00, frac[1]}) - (s2_c_ff[1] ? ONE_S : '0);
      oz  = $signed({2'b00, frac[2]}) - (s2_c_ff[0] ? ONE_S : '0);
      wx  = s2_c_ff[2] ? sm_ff[0] : ONE_W - sm_ff[0];
      wy  = s2_c_ff[1] ? sm_ff[1] : ONE_W - sm_ff[1];
      wz  = s2_c_ff[0] ? sm_ff[2] : ONE_W - sm_ff[2];
      prx = gx * ox;
      pry = gy * oy;
      prz = gz * oz;
      wxy = wx * wy;
   end

   always_ff @(posedge clock) begin
      prx_ff <= prx;
      pry_ff <= pry;
      prz_ff <= prz;
      wxy_ff <= wxy[2*FRAC_BITS:FRAC_BITS];
      wz_ff  <= wz;
   end

   // stage 3: dot product and full corner weight
   localparam int SUM_W = GRAD_W + FRAC_BITS + 4;
   localparam int DOT_W = 20;
   logic signed [SUM_W-1:0]  dsum, dsh;
   logic [2*FRAC_BITS+1:0]   wful;
   logic signed [DOT_W-1:0]  dot_ff;
   logic [FRAC_BITS:0]       w_ff;

   always_comb begin
      dsum = SUM_W'(prx_ff) + SUM_W'(pry_ff) + SUM_W'(prz_ff);
      dsh  = dsum >>> GRAD_FRAC;
      wful = wxy_ff * wz_ff;
   end

   always_ff @(posedge clock) begin
      dot_ff <= dsh[DOT_W-1:0];
      w_ff   <= wful[2*FRAC_BITS:FRAC_BITS];
   end

   // stage 4: weighted term
   localparam int TERM_W = 22;
   logic signed [DOT_W+FRAC_BITS+1:0] tprod, tsh;
   logic signed [TERM_W-1:0]          term_ff;

   always_comb begin
      tprod = dot_ff * $signed({1'b0, w_ff});
      tsh   = tprod >>> FRAC_BITS;
   end

   always_ff @(posedge clock) term_ff <= tsh[TERM_W-1:0];

   // stage 5: octave noise sum, then octave accumulator
   logic signed [NOISE_W-1:0] noise_ff, noise_sh;
   logic signed [ACC_W-1:0]   acc_ff;

   assign noise_sh = noise_ff >>> cmd.octave;

   always_ff @(posedge clock) begin
      if (cmd.smooth_a) noise_ff <= '0;
      else if (s5_v_ff) noise_ff <= noise_ff + NOISE_W'(term_ff);
      if (cmd.load) acc_ff <= '0;
      else if (cmd.oct_end) acc_ff <= acc_ff + ACC_W'(noise_sh);
   end

   // result: absolute value when in turbulence mode, then saturate
   logic signed [ACC_W-1:0] mag, sat;
   logic                    rsp_valid_ff;
   logic signed [OUT_W-1:0] rsp_noise_ff;

   always_comb begin
      mag = (mode_ff && acc_ff < 0) ? -acc_ff : acc_ff;
      if (mag > ACC_W'(OUT_MAX))       sat = ACC_W'(OUT_MAX);
      else if (mag < -ACC_W'(OUT_MAX)) sat = -ACC_W'(OUT_MAX);
      else                             sat = mag;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.finish) rsp_valid_ff <= 1'b1;
      else if (rsp_ready) rsp_valid_ff <= 1'b0;
      if (cmd.finish) rsp_noise_ff <= sat[OUT_W-1:0];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_noise_ff;

   assign status.busy      = s1_v_ff | s2_v_ff | s3_v_ff | s4_v_ff | s5_v_ff;
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.oct_limit = (octaves_ff > OCT_LIMIT) ? OCT_LIMIT : octaves_ff;

endmodule

/* rtl/ptn_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptn_ctrl
// Sequencer: per octave runs smoothstep, issues eight corners, waits for the
// pipeline to drain, folds the octave in; then loads the result register.
// ----------------------------------------------------------------------------
module ptn_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [ptn_pkg::FUNC_W-1:0]  req_func,
   input  ptn_pkg::ptn_status_type     status,
   output ptn_pkg::ptn_cmd_type        cmd
);
   import ptn_pkg::*;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_SMOOTH_A = 3'd1;
   localparam logic [2:0] S_SMOOTH_B = 3'd2;
   localparam logic [2:0] S_ISSUE    = 3'd3;
   localparam logic [2:0] S_DRAIN    = 3'd4;
   localparam logic [2:0] S_OCT_END  = 3'd5;
   localparam logic [2:0] S_FINISH   = 3'd6;

   logic [2:0]       state_ff, state_in;
   logic [2:0]       corner_ff, corner_in;
   logic [OCT_W-1:0] octave_ff, octave_in;
   logic             accept;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in     = state_ff;
      corner_in    = corner_ff;
      octave_in    = octave_ff;
      cmd          = '0;
      cmd.load     = accept;
      cmd.corner   = corner_ff;
      cmd.octave   = octave_ff[2:0];
      case (state_ff)
         S_IDLE: begin
            octave_in = '0;
            if (accept && req_func == FUNC_EVAL)
               state_in = (status.oct_limit == '0) ? S_FINISH : S_SMOOTH_A;
         end
         S_SMOOTH_A: begin
            cmd.smooth_a = 1'b1;
            state_in     = S_SMOOTH_B;
         end
         S_SMOOTH_B: begin
            cmd.smooth_b = 1'b1;
            corner_in    = '0;
            state_in     = S_ISSUE;
         end
         S_ISSUE: begin
            cmd.issue = 1'b1;
            corner_in = corner_ff + 3'd1;
            if (corner_ff == 3'd7) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            if (!status.busy) state_in = S_OCT_END;
         end
         S_OCT_END: begin
            cmd.oct_end = 1'b1;
            octave_in   = octave_ff + OCT_W'(1);
            state_in    = (octave_in == status.oct_limit) ? S_FINISH : S_SMOOTH_A;
         end
         S_FINISH: begin
            // hold until the result register is free
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         corner_ff <= '0;
         octave_ff <= '0;
      end else begin
         state_ff  <= state_in;
         corner_ff <= corner_in;
         octave_ff <= octave_in;
      end
   end

endmodule

/* rtl/perlin_turbulence_noise.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// perlin_turbulence_noise
// 3-D gradient noise with octave turbulence in Q16.16; table loads and
// evaluation on one request channel, one result per evaluation.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req_     in   req_valid/req_ready  func, table_index, grad_x/y/z,
//                                     perm_value, point_x/y/z
//  rsp_     out  rsp_valid/rsp_ready  noise_value
//  csr_     in   csr_valid/csr_ready  index, wdata (always ready)
//
// An evaluation runs one pass per octave: smoothstep, eight corner issues into
// the corner pipeline with one port per table, a drain of that pipeline and a
// fold-in of the octave sum.
// A new request is taken only once the previous evaluation has reached the
// result register; a stalled result blocks just the final transfer.
// Reset is synchronous; table contents are not cleared.
// ----------------------------------------------------------------------------
module perlin_turbulence_noise (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ptn_pkg::FUNC_W-1:0]           req_func,
   input  logic [ptn_pkg::TAB_W-1:0]            req_table_index,
   input  logic signed [ptn_pkg::GRAD_W-1:0]    req_grad_x,
   input  logic signed [ptn_pkg::GRAD_W-1:0]    req_grad_y,
   input  logic signed [ptn_pkg::GRAD_W-1:0]    req_grad_z,
   input  logic [ptn_pkg::TAB_W-1:0]            req_perm_value,
   input  logic signed [ptn_pkg::PT_W-1:0]      req_point_x,
   input  logic signed [ptn_pkg::PT_W-1:0]      req_point_y,
   input  logic signed [ptn_pkg::PT_W-1:0]      req_point_z,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [ptn_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [ptn_pkg::CSR_DAT_W-1:0]        csr_wdata,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [ptn_pkg::OUT_W-1:0]     rsp_noise_value
);
   import ptn_pkg::*;

   ptn_cmd_type    cmd;
   ptn_status_type status;

   ptn_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_func  (req_func),
      .status    (status),
      .cmd       (cmd)
   );

   ptn_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_func        (req_func),
      .req_table_index (req_table_index),
      .req_grad_x      (req_grad_x),
      .req_grad_y      (req_grad_y),
      .req_grad_z      (req_grad_z),
      .req_perm_value  (req_perm_value),
      .req_point_x     (req_point_x),
      .req_point_y     (req_point_y),
      .req_point_z     (req_point_z),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_noise_value (rsp_noise_value)
   );

   // an accepted evaluation occupies the sequencer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func == FUNC_EVAL) |=> !req_ready)
      else $error("evaluation accepted but request channel still ready");

   // loads never raise a result
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_func != FUNC_EVAL && !rsp_valid) |=> !rsp_valid)
      else $error("result raised by a load");

   // result stays within the saturation bounds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_noise_value <= OUT_W'(OUT_MAX)) &&
                    (rsp_noise_value >= -OUT_W'(OUT_MAX)))
      else $error("result outside saturation range");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the gradient noise / turbulence block. Tables are
// loaded in full before any evaluation; a local noise predictor computes each
// expected value and a monitor compares every result transfer against it.
// ----------------------------------------------------------------------------
module tb_top;
   import ptn_pkg::*;

   // codes outside the defined sets
   localparam logic [FUNC_W-1:0]    FUNC_UNUSED_LO = 3'd5;
   localparam logic [FUNC_W-1:0]    FUNC_UNUSED_HI = 3'd7;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED     = 4'd9;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = FUNC_EVAL;
   logic [TAB_W-1:0]         req_table_index = '0;
   logic signed [GRAD_W-1:0] req_grad_x = '0, req_grad_y = '0, req_grad_z = '0;
   logic [TAB_W-1:0]         req_perm_value = '0;
   logic signed [PT_W-1:0]   req_point_x = '0, req_point_y = '0, req_point_z = '0;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_W-1:0]     csr_index = '0;
   logic [CSR_DAT_W-1:0]     csr_wdata = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [OUT_W-1:0]  rsp_noise_value;

   perlin_turbulence_noise dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predictor state
   logic signed [15:0] grad_tab [3][256];
   logic [7:0]         perm_tab [3][256];
   int unsigned        octaves_cfg = 7;
   bit                 abs_mode = 1'b1;

   logic signed [OUT_W-1:0] noise_queue [$];
   int  fail_count = 0;
   bit  stall_idle = 1'b0;
   int  burst_left = 0;

   function automatic longint floor_div(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint smoothstep(longint f);
      longint f2;
      f2 = (f * f) >>> FRAC_BITS;
      return (f2 * (3 * 65536 - 2 * f)) >>> FRAC_BITS;
   endfunction

   function automatic longint octave_noise(logic [31:0] c [3]);
      longint lat [3], fr [3], sm [3];
      longint sum, dot, w, wt [3];
      logic [7:0] h;
      int di, dj, dk, a;
      sum = 0;
      for (a = 0; a < 3; a++) begin
         lat[a] = longint'($signed(c[a])) >>> FRAC_BITS;
         fr[a]  = longint'(c[a][15:0]);
         sm[a]  = smoothstep(fr[a]);
      end
      for (di = 0; di < 2; di++)
         for (dj = 0; dj < 2; dj++)
            for (dk = 0; dk < 2; dk++) begin
               h = perm_tab[0][8'(lat[0] + di)] ^ perm_tab[1][8'(lat[1] + dj)]
                 ^ perm_tab[2][8'(lat[2] + dk)];
               dot = floor_div(longint'(grad_tab[0][h]) * (fr[0] - di * 65536)
                             + longint'(grad_tab[1][h]) * (fr[1] - dj * 65536)
                             + longint'(grad_tab[2][h]) * (fr[2] - dk * 65536),
                               GRAD_FRAC);
               wt[0] = di ? sm[0] : 65536 - sm[0];
               wt[1] = dj ? sm[1] : 65536 - sm[1];
               wt[2] = dk ? sm[2] : 65536 - sm[2];
               w = (((wt[0] * wt[1]) >>> FRAC_BITS) * wt[2]) >>> FRAC_BITS;
               sum += floor_div(dot * w, FRAC_BITS);
            end
      return sum;
   endfunction

   function automatic void predict_request(logic [2:0] fn, logic [7:0] idx,
         logic signed [15:0] gx, gy, gz, logic [7:0] pv, logic [31:0] px, py, pz);
      logic [31:0] c [3];
      longint acc;
      int unsigned n, o;
      case (fn)
         FUNC_GRAD: begin
            grad_tab[0][idx] = gx; grad_tab[1][idx] = gy; grad_tab[2][idx] = gz;
         end
         FUNC_PERM_X: perm_tab[0][idx] = pv;
         FUNC_PERM_Y: perm_tab[1][idx] = pv;
         FUNC_PERM_Z: perm_tab[2][idx] = pv;
         FUNC_EVAL: begin
            c[0] = px; c[1] = py; c[2] = pz;
            n = octaves_cfg > MAX_OCT ? MAX_OCT : octaves_cfg;
            acc = 0;
            for (o = 0; o < n; o++) begin
               acc += floor_div(octave_noise(c), o);
               c[0] = c[0] << 1; c[1] = c[1] << 1; c[2] = c[2] << 1;
            end
            if (abs_mode && acc < 0) acc = -acc;
            if (acc > OUT_MAX) acc = OUT_MAX;
            if (acc < -OUT_MAX) acc = -OUT_MAX;
            noise_queue.push_back(OUT_W'(acc));
         end
         default: ;
      endcase
   endfunction

   // result monitor with its own stall pattern
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (noise_queue.size() == 0) begin
            $error("unexpected result noise_value=%0d", rsp_noise_value);
            fail_count++;
         end else begin
            if (rsp_noise_value !== noise_queue[0]) begin
               $error("noise_value expected %0d actual %0d", noise_queue[0],
                      rsp_noise_value);
               fail_count++;
            end
            void'(noise_queue.pop_front());
         end
      end
   end

   always @(negedge clock) begin
      if (stall_idle) rsp_ready <= 1'b1;
      else rsp_ready <= ($urandom_range(0, 9) < 3) ? 1'b0 : 1'b1;
   end

   task automatic send_request(logic [2:0] fn, logic [7:0] idx,
         logic signed [15:0] gx, gy, gz, logic [7:0] pv, logic [31:0] px, py, pz);
      // sender bursts with random gaps
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 6)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_func <= fn; req_table_index <= idx;
      req_grad_x <= gx; req_grad_y <= gy; req_grad_z <= gz;
      req_perm_value <= pv;
      req_point_x <= px; req_point_y <= py; req_point_z <= pz;
      do @(posedge clock); while (!req_ready);
      predict_request(fn, idx, gx, gy, gz, pv, px, py, pz);
      @(negedge clock);
      // hold valid inside a burst; the next transfer replaces the payload
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   // drop valid when a burst is cut short
   task automatic close_burst();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
   endtask

   task automatic send_point(logic [31:0] px, py, pz);
      send_request(FUNC_EVAL, '0, '0, '0, '0, '0, px, py, pz);
   endtask

   task automatic drain_results();
      close_burst();
      while (noise_queue.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DAT_W-1:0] val);
      close_burst();
      csr_valid <= 1'b1; csr_index <= idx; csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_OCTAVES) octaves_cfg = val;
      else if (idx == CSR_MODE) abs_mode = val[0];
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_point();
      case ($urandom_range(0, 3))
         0: return $urandom;
         1: return {{16{1'b0}}, 16'($urandom)} - 32'(1 << 20);
         2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
         default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      endcase
   endfunction

   function automatic logic signed [15:0] random_grad();
      case ($urandom_range(0, 4))
         0: return 16'sd16384;
         1: return -16'sd16384;
         default: return 16'($signed($urandom_range(0, 32768)) - 16384);
      endcase
   endfunction

   task automatic test_table_load();
      int i, t;
      for (i = 0; i < 256; i++)
         send_request(FUNC_GRAD, 8'(i), random_grad(), random_grad(), random_grad(),
                      '0, '0, '0, '0);
      for (t = 0; t < 3; t++)
         for (i = 0; i < 256; i++)
            send_request(FUNC_PERM_X + 3'(t), 8'(i), '0, '0, '0, 8'($urandom), '0, '0, '0);
   endtask

   task automatic test_directed();
      send_point('0, '0, '0);
      send_point(32'h7fffffff, 32'h80000000, 32'h0000ffff);
      send_point(32'h80000000, 32'h7fffffff, 32'hffff0000);
      send_point(32'h00008000, 32'hffff8000, 32'h00018000);
      // unused codes are dropped
      send_request(FUNC_UNUSED_LO, 8'hff, 16'sh7fff, 16'sh8000, '1, '1, '1, '1, '1);
      send_request(FUNC_UNUSED_HI, '0, '0, '0, '0, '0, '0, '0, '0);
      // rewrite gradient entry 0 with extremes and the last X permutation entry
      send_request(FUNC_GRAD, 8'd0, 16'sd16384, -16'sd16384, 16'sd16384, '0, '0, '0, '0);
      send_request(FUNC_PERM_X, 8'd255, '0, '0, '0, 8'hff, '0, '0, '0);
      send_point(32'h00ff4000, 32'h00ff4000, 32'h00ff4000);
      drain_results();
   endtask

   task automatic test_config_sweep();
      int m, k;
      int oct_set [6] = '{0, 1, 8, 9, 15, 3};
      for (k = 0; k < 6; k++) begin
         for (m = 0; m < 2; m++) begin
            write_register(CSR_OCTAVES, 4'(oct_set[k]));
            write_register(CSR_MODE, 4'(m));
            write_register(CSR_UNUSED, 4'hf); // beyond the register file: ignored
            send_point('0, '0, '0);
            send_point(32'h7fffffff, 32'h80000000, random_point());
            send_point(random_point(), random_point(), random_point());
            drain_results();
         end
      end
   endtask

   task automatic test_random(int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 100 == 50) begin
            drain_results();
            write_register(CSR_OCTAVES, 4'($urandom_range(0, 15)));
            write_register(CSR_MODE, 4'($urandom_range(0, 1)));
         end
         if (i % 150 == 120) stall_idle = ~stall_idle;
         case ($urandom_range(0, 9))
            0: send_request(FUNC_GRAD, 8'($urandom), random_grad(), random_grad(),
                            random_grad(), '0, '0, '0, '0);
            1: send_request(3'($urandom_range(FUNC_PERM_X, FUNC_UNUSED_HI)), 8'($urandom),
                            '0, '0, '0, 8'($urandom), '0, '0, '0);
            default: send_point(random_point(), random_point(), random_point());
         endcase
      end
      drain_results();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_table_load();
      test_directed();
      test_config_sweep();
      test_random(600);
      if (fail_count == 0 && noise_queue.size() == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #20ms;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
